// ----- rtl/core/dpsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and register codes for the dual pedal sensor plausibility unit.
// Used by every module in rtl/core.

package dpsp_pkg;

    localparam int ADC_BITS   = 12;
    localparam int FRAC_BITS  = 15;
    localparam int POS_W      = FRAC_BITS + 1;
    localparam int OUT_W      = 16;
    localparam int TOL_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = $clog2(FRAC_BITS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_A_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 3'd6;

    localparam logic [ADC_BITS-1:0] RAW_MIN_RST = '0;
    localparam logic [ADC_BITS-1:0] RAW_MAX_RST = {ADC_BITS{1'b1}};
    localparam logic [TOL_W-1:0]    TOL_RST     = 16'd3277;
    localparam logic [TOL_W-1:0]    THR_RST     = 16'd1638;
    localparam logic [TOL_W-1:0]    DELAY_RST   = 16'd100;

    localparam logic [POS_W-1:0] FULL_SCALE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic [ADC_BITS-1:0] sample_a;
        logic [ADC_BITS-1:0] sample_b;
        logic                adc_ok;
        logic [TIME_W-1:0]   now_ms;
    } t_in_req;

    typedef struct packed {
        logic [OUT_W-1:0] position;
        logic [OUT_W-1:0] position_a;
        logic [OUT_W-1:0] position_b;
        logic             mismatch;
        logic             fault;
    } t_out_req;

    typedef struct packed {
        logic busy;
        logic zero;
        logic full;
    } t_norm_sta;

    typedef struct packed {
        logic [TOL_W-1:0] tolerance;
        logic [TOL_W-1:0] threshold;
        logic [TOL_W-1:0] delay_ms;
    } t_chk_cfg;

    // Keep the low output bits of a position, zero-extending narrow ones.
    function automatic logic [OUT_W-1:0] fit_out(input logic [POS_W-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        return ext[OUT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/dpsp_norm.sv -----
`timescale 1ns / 1ps
// Bit-serial normalizer: restoring division of (raw - lo) << FRAC_BITS by (hi - lo).
// One quotient bit per cycle; depends on dpsp_pkg.

module dpsp_norm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dpsp_pkg::ADC_BITS-1:0] i_raw,
    input  logic [dpsp_pkg::ADC_BITS-1:0] i_lo,
    input  logic [dpsp_pkg::ADC_BITS-1:0] i_hi,
    output dpsp_pkg::t_norm_sta           o_sta,
    output logic [dpsp_pkg::POS_W-1:0]    o_pos
);
    import dpsp_pkg::*;

    logic                 r_busy, n_busy;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [ADC_BITS-1:0]  r_rem, n_rem;
    logic [ADC_BITS-1:0]  r_span, n_span;
    logic [FRAC_BITS-1:0] r_quo, n_quo;
    logic                 r_zero, n_zero;
    logic                 r_full, n_full;

    logic [ADC_BITS:0] w_rem2;
    logic [ADC_BITS:0] w_sub;
    logic              w_ge;
    logic              w_zero;
    logic              w_full;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_span};
    assign w_sub  = w_rem2 - {1'b0, r_span};
    assign w_zero = (i_hi <= i_lo) || (i_raw <= i_lo);
    assign w_full = !w_zero && (i_raw >= i_hi);

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_span = r_span;
        n_quo  = r_quo;
        n_zero = r_zero;
        n_full = r_full;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(FRAC_BITS);
            // special cases still run the full sweep; the output mux overrides
            n_rem  = (w_zero || w_full) ? '0 : i_raw - i_lo;
            n_span = i_hi - i_lo;
            n_quo  = '0;
            n_zero = w_zero;
            n_full = w_full;
        end else if (r_busy) begin
            n_rem = w_ge ? w_sub[ADC_BITS-1:0] : w_rem2[ADC_BITS-1:0];
            n_quo = {r_quo[FRAC_BITS-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_span <= n_span;
        r_quo  <= n_quo;
        r_zero <= n_zero;
        r_full <= n_full;
    end

    assign o_sta.busy = r_busy;
    assign o_sta.zero = r_zero;
    assign o_sta.full = r_full;

    always_comb begin
        if (r_zero) begin
            o_pos = '0;
        end else if (r_full) begin
            o_pos = FULL_SCALE;
        end else begin
            o_pos = {1'b0, r_quo};
        end
    end

endmodule

// ----- rtl/core/dpsp_check.sv -----
`timescale 1ns / 1ps
// Agreement check, mismatch persistence timer and result assembly.
// Depends on dpsp_pkg.

module dpsp_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_commit,
    input  logic [dpsp_pkg::POS_W-1:0]  i_pos_a,
    input  logic [dpsp_pkg::POS_W-1:0]  i_pos_b,
    input  logic [dpsp_pkg::TIME_W-1:0] i_now_ms,
    input  dpsp_pkg::t_chk_cfg          i_cfg,
    output dpsp_pkg::t_out_req          o_res
);
    import dpsp_pkg::*;

    logic              r_pending, n_pending;
    logic [TIME_W-1:0] r_start, n_start;

    logic [POS_W-1:0]  w_diff;
    logic [POS_W:0]    w_sum;
    logic [POS_W-1:0]  w_avg;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_mis;
    logic              w_flt;

    assign w_diff    = (i_pos_a > i_pos_b) ? i_pos_a - i_pos_b : i_pos_b - i_pos_a;
    assign w_sum     = {1'b0, i_pos_a} + {1'b0, i_pos_b};
    assign w_avg     = w_sum[POS_W:1];
    assign w_elapsed = i_now_ms - r_start;

    assign w_mis = (32'(w_diff) > 32'(i_cfg.tolerance)) &&
                   ((32'(i_pos_a) > 32'(i_cfg.threshold)) ||
                    (32'(i_pos_b) > 32'(i_cfg.threshold)));
    // fault only on a continuing mismatch, never on the first one
    assign w_flt = w_mis && r_pending && (w_elapsed >= TIME_W'(i_cfg.delay_ms));

    always_comb begin
        n_pending = r_pending;
        n_start   = r_start;
        if (i_commit) begin
            n_pending = w_mis;
            if (w_mis && !r_pending) begin
                n_start = i_now_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_start   <= '0;
        end else begin
            r_pending <= n_pending;
            r_start   <= n_start;
        end
    end

    assign o_res.position   = fit_out(w_avg);
    assign o_res.position_a = fit_out(i_pos_a);
    assign o_res.position_b = fit_out(i_pos_b);
    assign o_res.mismatch   = w_mis;
    assign o_res.fault      = w_flt;

endmodule

// ----- rtl/core/dual_pedal_sensor_plausibility_unit.sv -----
`timescale 1ns / 1ps
// A request is accepted only in the idle state; both dividers then run in the divide state, and
// the result is committed from the done state into the output register before the next is taken.
// A new request is taken while the previous result still waits in the output register.
// Reset (synchronous, active low): registers to defaults, mismatch timer cleared, no result.
// Depends on dpsp_pkg, dpsp_norm and dpsp_check.

module dual_pedal_sensor_plausibility_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  dpsp_pkg::t_in_req               i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output dpsp_pkg::t_out_req              o_out_req,
    input  logic                            i_cfg_we,
    input  logic [dpsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dpsp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dpsp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          r_state, n_state;
    logic                r_out_valid, n_out_valid;
    t_out_req            r_out, n_out;
    logic [TIME_W-1:0]   r_now, n_now;

    logic [ADC_BITS-1:0] r_a_min, r_a_max, r_b_min, r_b_max;
    logic [TOL_W-1:0]    r_tol, r_thr, r_delay;

    logic                w_accept;
    logic                w_commit;
    logic [ADC_BITS-1:0] w_raw_a, w_raw_b;
    t_norm_sta           w_sta_a, w_sta_b;
    logic [POS_W-1:0]    w_pos_a, w_pos_b;
    t_chk_cfg            w_cfg;
    t_out_req            w_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_commit   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign w_raw_a = i_in_req.adc_ok ? i_in_req.sample_a : '0;
    assign w_raw_b = i_in_req.adc_ok ? i_in_req.sample_b : '0;

    assign w_cfg.tolerance = r_tol;
    assign w_cfg.threshold = r_thr;
    assign w_cfg.delay_ms  = r_delay;

    dpsp_norm u_norm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_raw   (w_raw_a),
        .i_lo    (r_a_min),
        .i_hi    (r_a_max),
        .o_sta   (w_sta_a),
        .o_pos   (w_pos_a)
    );

    dpsp_norm u_norm_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_raw   (w_raw_b),
        .i_lo    (r_b_min),
        .i_hi    (r_b_max),
        .o_sta   (w_sta_b),
        .o_pos   (w_pos_b)
    );

    dpsp_check u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (w_commit),
        .i_pos_a  (w_pos_a),
        .i_pos_b  (w_pos_b),
        .i_now_ms (r_now),
        .i_cfg    (w_cfg),
        .o_res    (w_res)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_now       = r_now;
        if (o_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_now   = i_in_req.now_ms;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!w_sta_a.busy && !w_sta_b.busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (w_commit) begin
                    n_out       = w_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_now <= n_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_min <= RAW_MIN_RST;
            r_a_max <= RAW_MAX_RST;
            r_b_min <= RAW_MIN_RST;
            r_b_max <= RAW_MAX_RST;
            r_tol   <= TOL_RST;
            r_thr   <= THR_RST;
            r_delay <= DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_A_MIN:     r_a_min <= i_cfg_data[ADC_BITS-1:0];
                CFG_A_MAX:     r_a_max <= i_cfg_data[ADC_BITS-1:0];
                CFG_B_MIN:     r_b_min <= i_cfg_data[ADC_BITS-1:0];
                CFG_B_MAX:     r_b_max <= i_cfg_data[ADC_BITS-1:0];
                CFG_TOLERANCE: r_tol   <= i_cfg_data[TOL_W-1:0];
                CFG_THRESHOLD: r_thr   <= i_cfg_data[TOL_W-1:0];
                CFG_DELAY:     r_delay <= i_cfg_data[TOL_W-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (w_sta_a.busy && w_sta_b.busy))
        else $error("dividers did not start on request accept");

    a_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sta_a.busy || w_sta_b.busy) |-> (r_state == S_DIV))
        else $error("divider busy outside the divide state");

    a_fault_needs_mismatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.fault) |-> o_out_req.mismatch)
        else $error("fault reported without mismatch");

    a_commit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("committed result not presented");
`endif

endmodule

// ----- tb/tb_dual_pedal_sensor_plausibility_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dual_pedal_sensor_plausibility_unit: directed and random requests
// with random idling on both channels, checked against an in-bench pedal plausibility predictor.
// Depends on dpsp_pkg and the RTL under rtl/core.

module tb_dual_pedal_sensor_plausibility_unit;

    import dpsp_pkg::*;

    localparam int                   CLK_HALF     = 4;
    localparam int                   FULL         = 1 << FRAC_BITS;
    localparam int                   FLUSH_CYCLES = FRAC_BITS + 8;
    localparam int                   CYCLE_LIMIT  = 600000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_req               i_in_req;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_req              o_out_req;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor copy of the registers and the mismatch timer
    logic [ADC_BITS-1:0] a_min, a_max, b_min, b_max;
    logic [TOL_W-1:0]    tolerance, threshold, delay_ms;
    logic                timer_running;
    logic [TIME_W-1:0]   timer_start_ms;

    t_out_req            expected_readings[$];
    logic [TIME_W-1:0]   clock_ms;
    int                  n_sent, n_checked, n_errors, n_mismatch, n_fault, n_setups;
    int                  cycle_cnt;
    bit                  idle_en;
    int                  rx_hold;

    dual_pedal_sensor_plausibility_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still awaited", $realtime,
                     expected_readings.size());
            $display("tb_dual_pedal_sensor_plausibility_unit NOT OK");
            $finish;
        end
    end

    function automatic int pedal_fraction(input logic [ADC_BITS-1:0] raw,
                                          input logic [ADC_BITS-1:0] lo,
                                          input logic [ADC_BITS-1:0] hi);
        logic [47:0] q;
        if (hi <= lo || raw <= lo) return 0;
        q = (48'(raw - lo) << FRAC_BITS) / 48'(hi - lo);
        if (q > 48'(FULL)) q = 48'(FULL);
        return int'(q);
    endfunction

    function automatic t_out_req predict_pedal(input t_in_req r);
        t_out_req            res;
        logic [ADC_BITS-1:0] raw_a, raw_b;
        logic [31:0]         pa, pb, diff, elapsed;
        logic                mis, flt;
        raw_a = r.adc_ok ? r.sample_a : '0;
        raw_b = r.adc_ok ? r.sample_b : '0;
        pa = pedal_fraction(raw_a, a_min, a_max);
        pb = pedal_fraction(raw_b, b_min, b_max);
        diff = (pa > pb) ? pa - pb : pb - pa;
        mis = (diff > 32'(tolerance)) && (pa > 32'(threshold) || pb > 32'(threshold));
        flt = 1'b0;
        elapsed = r.now_ms - timer_start_ms;
        if (mis) begin
            if (!timer_running) begin
                timer_running = 1'b1;
                timer_start_ms = r.now_ms;
            end else if (elapsed >= 32'(delay_ms)) begin
                flt = 1'b1;
            end
        end else begin
            timer_running = 1'b0;
        end
        res.position   = 16'((pa + pb) >> 1);
        res.position_a = 16'(pa);
        res.position_b = 16'(pb);
        res.mismatch   = mis;
        res.fault      = flt;
        return res;
    endfunction

    function automatic int clamp_frac(input int v);
        if (v < 0) return 0;
        if (v > FULL) return FULL;
        return v;
    endfunction

    // Raw reading that lands near the given position, with a little noise
    function automatic logic [ADC_BITS-1:0] raw_for(input int frac,
                                                    input logic [ADC_BITS-1:0] lo,
                                                    input logic [ADC_BITS-1:0] hi);
        int v;
        if (hi <= lo) return ADC_BITS'($urandom_range(0, (1 << ADC_BITS) - 1));
        v = int'(lo) + (frac * (int'(hi) - int'(lo))) / FULL + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > (1 << ADC_BITS) - 1) v = (1 << ADC_BITS) - 1;
        return ADC_BITS'(v);
    endfunction

    function automatic t_in_req pedal_sample(input int a, input int b, input bit ok,
                                             input logic [TIME_W-1:0] t);
        t_in_req r;
        r.sample_a = ADC_BITS'(a);
        r.sample_b = ADC_BITS'(b);
        r.adc_ok   = ok;
        r.now_ms   = t;
        return r;
    endfunction

    function automatic int next_gap();
        return idle_en ? int'($urandom_range(0, 19)) : 0;
    endfunction

    // Valid stays high across back-to-back requests; drop it only ahead of a gap
    task automatic offer_sample(input t_in_req r, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        expected_readings.push_back(predict_pedal(r));
        n_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_A_MIN:     a_min     = data[ADC_BITS-1:0];
            CFG_A_MAX:     a_max     = data[ADC_BITS-1:0];
            CFG_B_MIN:     b_min     = data[ADC_BITS-1:0];
            CFG_B_MAX:     b_max     = data[ADC_BITS-1:0];
            CFG_TOLERANCE: tolerance = data;
            CFG_THRESHOLD: threshold = data;
            CFG_DELAY:     delay_ms  = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
    endtask

    // Upper data bits of the 12-bit registers carry noise that must be dropped
    task automatic write_setup(input int amn, input int amx, input int bmn, input int bmx,
                               input int tol, input int thr, input int dly);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom_range(0, 15)) << ADC_BITS;
        write_reg(CFG_A_MIN, junk | CFG_DATA_W'(amn));
        write_reg(CFG_A_MAX, junk ^ CFG_DATA_W'(amx));
        write_reg(CFG_B_MIN, ~junk & CFG_DATA_W'(bmn) | junk);
        write_reg(CFG_B_MAX, CFG_DATA_W'(bmx) | (~junk & 16'hF000));
        write_reg(CFG_TOLERANCE, CFG_DATA_W'(tol));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_DELAY, CFG_DATA_W'(dly));
        n_setups++;
    endtask

    // Episodes of steady agreement, steady disagreement, noise and failed conversions
    task automatic run_episodes(input int count);
        int      done, kind, len, k, f, off, fb;
        t_in_req r;
        done = 0;
        while (done < count) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(3, 30);
            f    = $urandom_range(0, FULL);
            off  = $urandom_range(0, 24000);
            if (kind == 9) begin
                clock_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300)
                                                       : TIME_W'($urandom);
            end
            for (k = 0; k < len && done < count; k++) begin
                clock_ms += $urandom_range(0, 12);
                r.now_ms = clock_ms;
                r.adc_ok = 1'b1;
                case (kind)
                    4, 5, 6: begin
                        fb = clamp_frac(($urandom_range(0, 1) != 0) ? f + off : f - off);
                        r.sample_a = raw_for(f, a_min, a_max);
                        r.sample_b = raw_for(fb, b_min, b_max);
                    end
                    7: begin
                        r.sample_a = ADC_BITS'($urandom);
                        r.sample_b = ADC_BITS'($urandom);
                        r.adc_ok   = 1'($urandom_range(0, 1));
                    end
                    8: begin
                        r.sample_a = ADC_BITS'($urandom);
                        r.sample_b = ADC_BITS'($urandom);
                        r.adc_ok   = ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        r.sample_a = raw_for(f, a_min, a_max);
                        r.sample_b = raw_for(f, b_min, b_max);
                    end
                endcase
                f = clamp_frac(f + int'($urandom_range(0, 400)) - 200);
                offer_sample(r, next_gap());
                done++;
            end
        end
    endtask

    task automatic test_default_setup();
        offer_sample(pedal_sample(0, 0, 1, 32'd0), next_gap());
        offer_sample(pedal_sample(4095, 4095, 1, 32'd5), next_gap());
        offer_sample(pedal_sample(2000, 3000, 0, 32'd10), next_gap());
        // Mismatch first seen, held below the delay, then reaching it
        offer_sample(pedal_sample(4095, 0, 1, 32'd1000), next_gap());
        offer_sample(pedal_sample(4095, 0, 1, 32'd1050), next_gap());
        offer_sample(pedal_sample(4095, 0, 1, 32'd1099), next_gap());
        offer_sample(pedal_sample(4095, 0, 1, 32'd1100), next_gap());
        offer_sample(pedal_sample(0, 0, 1, 32'd1105), next_gap());
        // Timer across the tick wrap
        offer_sample(pedal_sample(0, 4095, 1, 32'hFFFF_FFC0), next_gap());
        offer_sample(pedal_sample(0, 4095, 1, 32'h0000_0030), next_gap());
        offer_sample(pedal_sample(150, 0, 1, 32'h0000_0035), next_gap());
        settle();
    endtask

    task automatic test_register_extremes();
        // Zero span on A, negative span on B
        write_setup(1000, 1000, 3000, 2000, 3277, 1638, 100);
        offer_sample(pedal_sample(2000, 3500, 1, 32'd20), next_gap());
        settle();
        // Below minimum, at minimum, above maximum
        write_setup(1000, 3000, 500, 600, 3277, 1638, 100);
        offer_sample(pedal_sample(999, 601, 1, 32'd30), next_gap());
        offer_sample(pedal_sample(1000, 500, 1, 32'd35), next_gap());
        offer_sample(pedal_sample(4095, 4095, 1, 32'd40), next_gap());
        settle();
        // Zero tolerance, threshold and delay: fault on the second mismatched sample
        write_setup(0, 4095, 0, 4095, 0, 0, 0);
        offer_sample(pedal_sample(0, 0, 1, 32'd50), next_gap());
        offer_sample(pedal_sample(10, 11, 1, 32'd50), next_gap());
        offer_sample(pedal_sample(10, 11, 1, 32'd50), next_gap());
        settle();
        // Tolerance or threshold at or above full scale never fires
        write_setup(0, 4095, 0, 4095, 32768, 0, 0);
        offer_sample(pedal_sample(4095, 0, 1, 32'd60), next_gap());
        settle();
        write_setup(0, 4095, 0, 4095, 0, 65535, 0);
        offer_sample(pedal_sample(0, 4095, 1, 32'd70), next_gap());
        settle();
        // Disagreement while both stay under the activity threshold
        write_setup(0, 4095, 0, 4095, 100, 20000, 0);
        offer_sample(pedal_sample(1000, 2000, 1, 32'd80), next_gap());
        settle();
        // Longest delay, checked one tick short and exactly at it
        write_setup(0, 4095, 0, 4095, 65535 - 65535 + 3277, 1638, 65535);
        offer_sample(pedal_sample(4095, 0, 1, 32'd100), next_gap());
        offer_sample(pedal_sample(4095, 0, 1, 32'd65634), next_gap());
        offer_sample(pedal_sample(4095, 0, 1, 32'd65635), next_gap());
        settle();
        // Write to the unused index must leave the setup alone
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        offer_sample(pedal_sample(4095, 0, 1, 32'd65640), next_gap());
        settle();
    endtask

    task automatic pick_setup(input int style);
        case (style)
            4: write_setup(0, 4095, 4095, 0, 0, 0, 0);
            5: write_setup(2048, 2048, 0, 4095, 32768, 32768, 65535);
            3: write_setup($urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 200));
            default: write_setup($urandom_range(0, 800), $urandom_range(3000, 4095),
                                 $urandom_range(0, 800), $urandom_range(3000, 4095),
                                 $urandom_range(500, 6000), $urandom_range(0, 4000),
                                 $urandom_range(0, 80));
        endcase
    endtask

    task automatic test_random_traffic();
        int p;
        for (p = 0; p < 11; p++) begin
            pick_setup((p == 1) ? 4 : (p == 2) ? 5 : int'($urandom_range(0, 3)));
            idle_en = (p != 6);
            run_episodes(92);
            settle();
        end
        idle_en = 1'b1;
    endtask

    task automatic test_sink_hold_off();
        pick_setup(0);
        idle_en = 1'b0;
        rx_hold = 300;
        run_episodes(24);
        settle();
        idle_en = 1'b1;
    endtask

    task automatic test_sender_pause();
        run_episodes(12);
        settle();
        run_episodes(12);
        settle();
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: result without request, expected none, actual %h", $realtime,
                         o_out_req);
                n_errors++;
            end else begin
                want = expected_readings.pop_front();
                compare_field("position", want.position, o_out_req.position);
                compare_field("position_a", want.position_a, o_out_req.position_a);
                compare_field("position_b", want.position_b, o_out_req.position_b);
                compare_field("mismatch", 16'(want.mismatch), 16'(o_out_req.mismatch));
                compare_field("fault", 16'(want.fault), 16'(o_out_req.fault));
                n_checked++;
                n_mismatch += int'(want.mismatch);
                n_fault    += int'(want.fault);
            end
        end
    end

    // Result sink: random stall before each result, plus an optional long hold-off
    initial begin : result_sink
        int n;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            n = next_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        a_min      = RAW_MIN_RST;
        a_max      = RAW_MAX_RST;
        b_min      = RAW_MIN_RST;
        b_max      = RAW_MAX_RST;
        tolerance  = TOL_RST;
        threshold  = THR_RST;
        delay_ms   = DELAY_RST;
        timer_running  = 1'b0;
        timer_start_ms = '0;
        clock_ms   = '0;
        idle_en    = 1'b1;
        rx_hold    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_setup();
        test_register_extremes();
        test_random_traffic();
        test_sink_hold_off();
        test_sender_pause();

        settle();
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        n_errors += expected_readings.size();
        $display("Ran %0d pedal samples over %0d register setups, %0d results checked",
                 n_sent, n_setups, n_checked);
        $display("Mismatch flagged on %0d results, fault on %0d, %0d errors",
                 n_mismatch, n_fault, n_errors);
        if (n_errors == 0) begin
            $display("tb_dual_pedal_sensor_plausibility_unit OK");
        end else begin
            $display("tb_dual_pedal_sensor_plausibility_unit NOT OK");
        end
        $finish;
    end

endmodule
